@@ rtl/core/lex_pkg.sv @@
package lex_pkg;

    // Record kinds on the result channel.
    localparam logic [1:0] REC_TOKEN = 2'd0;
    localparam logic [1:0] REC_ERROR = 2'd1;
    localparam logic [1:0] REC_END   = 2'd2;
    localparam logic [1:0] REC_TEXT  = 2'd3;

    // Token classes.
    localparam logic [5:0] TOK_IDENT   = 6'd0;
    localparam logic [5:0] TOK_PLUS    = 6'd1;
    localparam logic [5:0] TOK_MINUS   = 6'd2;
    localparam logic [5:0] TOK_STAR    = 6'd3;
    localparam logic [5:0] TOK_SLASH   = 6'd4;
    localparam logic [5:0] TOK_LPAREN  = 6'd5;
    localparam logic [5:0] TOK_RPAREN  = 6'd6;
    localparam logic [5:0] TOK_LBRACK  = 6'd7;
    localparam logic [5:0] TOK_RBRACK  = 6'd8;
    localparam logic [5:0] TOK_LBRACE  = 6'd9;
    localparam logic [5:0] TOK_RBRACE  = 6'd10;
    localparam logic [5:0] TOK_COMMA   = 6'd11;
    localparam logic [5:0] TOK_SEMI    = 6'd12;
    localparam logic [5:0] TOK_COLON   = 6'd13;
    localparam logic [5:0] TOK_LT      = 6'd16;
    localparam logic [5:0] TOK_LE      = 6'd17;
    localparam logic [5:0] TOK_GT      = 6'd18;
    localparam logic [5:0] TOK_GE      = 6'd19;
    localparam logic [5:0] TOK_EQEQ    = 6'd20;
    localparam logic [5:0] TOK_NE      = 6'd21;
    localparam logic [5:0] TOK_ASSIGN  = 6'd22;
    localparam logic [5:0] TOK_KW_BASE = 6'd23;
    localparam logic [5:0] TOK_INT     = 6'd36;
    localparam logic [5:0] TOK_CHAR    = 6'd37;
    localparam logic [5:0] TOK_STRING  = 6'd38;

    // Error codes.
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_TOO_LONG  = 4'd1;
    localparam logic [3:0] ERR_LEAD_ZERO = 4'd2;
    localparam logic [3:0] ERR_TOO_LARGE = 4'd3;
    localparam logic [3:0] ERR_BAD_CHAR  = 4'd4;
    localparam logic [3:0] ERR_NO_QUOTE  = 4'd5;
    localparam logic [3:0] ERR_NO_DQUOTE = 4'd6;
    localparam logic [3:0] ERR_LONE_BANG = 4'd7;
    localparam logic [3:0] ERR_ILLEGAL   = 4'd8;

    // Configuration register indexes.
    localparam logic REG_INT_LIMIT  = 1'b0;
    localparam logic REG_TEXT_LIMIT = 1'b1;

    localparam logic [31:0] IntLimitReset  = 32'd2147483648;
    localparam logic [7:0]  TextLimitReset = 8'd128;
    localparam int          NumKeywords    = 13;
    localparam logic [12:0] KwAll          = 13'h1FFF;
    localparam int          RecSlots       = 4;
    localparam int          QueueDepth     = 4;
    localparam logic [19:0] LineMax        = 20'hFFFFF;
    localparam logic [15:0] ColMax         = 16'hFFFF;

    // Character codes.
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TILDE  = 8'd126;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_IDENT     = 14'b00000000000010,
        ST_IDENT_OVF = 14'b00000000000100,
        ST_INT       = 14'b00000000001000,
        ST_ZERO      = 14'b00000000010000,
        ST_INT_OVF   = 14'b00000000100000,
        ST_CHAR_OPEN = 14'b00000001000000,
        ST_CHAR_GOT  = 14'b00000010000000,
        ST_STR       = 14'b00000100000000,
        ST_STR_OVF   = 14'b00001000000000,
        ST_LT        = 14'b00010000000000,
        ST_GT        = 14'b00100000000000,
        ST_EQ        = 14'b01000000000000,
        ST_BANG      = 14'b10000000000000
    } scan_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  tok;
        logic [31:0] ival;
        logic [7:0]  cval;
        logic [7:0]  tlen;
        logic [3:0]  err;
    } rec_t;

    // All records caused by one input byte, with the position they report.
    typedef struct packed {
        rec_t [RecSlots-1:0] recs;
        logic [2:0]          count;
        logic [19:0]         line;
        logic [15:0]         col;
    } bundle_t;

    function automatic rec_t mk_rec(input logic [1:0] kind, input logic [5:0] tok,
                                    input logic [31:0] ival, input logic [7:0] cval,
                                    input logic [7:0] tlen, input logic [3:0] err);
        rec_t r;
        r.kind = kind;
        r.tok  = tok;
        r.ival = ival;
        r.cval = cval;
        r.tlen = tlen;
        r.err  = err;
        return r;
    endfunction

    function automatic logic [63:0] kw_word(input logic [3:0] j);
        logic [63:0] w;
        case (j)
            4'd0:    w = "int";
            4'd1:    w = "char";
            4'd2:    w = "const";
            4'd3:    w = "void";
            4'd4:    w = "if";
            4'd5:    w = "while";
            4'd6:    w = "switch";
            4'd7:    w = "case";
            4'd8:    w = "default";
            4'd9:    w = "return";
            4'd10:   w = "main";
            4'd11:   w = "printf";
            4'd12:   w = "scanf";
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] j);
        logic [2:0] n;
        case (j)
            4'd0:    n = 3'd3;
            4'd1:    n = 3'd4;
            4'd2:    n = 3'd5;
            4'd3:    n = 3'd4;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd5;
            4'd6:    n = 3'd6;
            4'd7:    n = 3'd4;
            4'd8:    n = 3'd7;
            4'd9:    n = 3'd6;
            4'd10:   n = 3'd4;
            4'd11:   n = 3'd6;
            4'd12:   n = 3'd5;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Character k of keyword j; the literal is stored right-aligned.
    function automatic logic [7:0] kw_char(input logic [3:0] j, input logic [2:0] k);
        logic [63:0] w;
        logic [2:0]  idx;
        w   = kw_word(j);
        idx = kw_len(j) - 3'd1 - k;
        return w[{idx, 3'b000} +: 8];
    endfunction

    // Drops keywords that no longer match once character c lands at position pos.
    function automatic logic [12:0] kw_filter(input logic [12:0] cand, input logic [7:0] pos,
                                              input logic [7:0] c);
        logic [12:0] m;
        m = cand;
        for (int j = 0; j < NumKeywords; j++) begin
            if (pos >= {5'd0, kw_len(4'(j))} || kw_char(4'(j), pos[2:0]) != c) begin
                m[j] = 1'b0;
            end
        end
        return m;
    endfunction

    // Token class of a finished identifier; the highest matching keyword wins.
    function automatic logic [5:0] kw_kind(input logic [12:0] cand, input logic [7:0] len);
        logic [5:0] k;
        k = TOK_IDENT;
        for (int j = 0; j < NumKeywords; j++) begin
            if (cand[j] && len == {5'd0, kw_len(4'(j))}) begin
                k = TOK_KW_BASE + 6'(j);
            end
        end
        return k;
    endfunction

    function automatic logic [5:0] simple_tok(input logic [7:0] c);
        logic [5:0] t;
        case (c)
            "+":     t = TOK_PLUS;
            "-":     t = TOK_MINUS;
            "*":     t = TOK_STAR;
            "/":     t = TOK_SLASH;
            "(":     t = TOK_LPAREN;
            ")":     t = TOK_RPAREN;
            "[":     t = TOK_LBRACK;
            "]":     t = TOK_RBRACK;
            "{":     t = TOK_LBRACE;
            "}":     t = TOK_RBRACE;
            ",":     t = TOK_COMMA;
            ";":     t = TOK_SEMI;
            ":":     t = TOK_COLON;
            default: t = TOK_IDENT;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/core/lex_front.sv @@
module lex_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_source_byte,
    input  logic              s_end_of_input,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              push_valid,
    input  logic              push_ready,
    output lex_pkg::bundle_t  push_data
);
    import lex_pkg::*;

    logic [31:0]  int_limit_reg;
    logic [7:0]   text_limit_reg;
    scan_state_t  state_reg, state_next;
    logic [31:0]  acc_reg, acc_next;
    logic [7:0]   tc_reg, tc_next;
    logic [12:0]  cand_reg, cand_next;
    logic [7:0]   held_reg, held_next;
    logic [19:0]  line_reg, line_next;
    logic [15:0]  col_reg, col_next;

    rec_t [RecSlots-1:0] recs;
    logic [2:0]   cnt;
    logic         redo;
    logic [7:0]   c;
    logic         is_al, is_dg, is_id, is_str;
    logic [35:0]  dig_sum;
    logic [8:0]   tc_wide;
    logic         accept;

    assign c      = s_source_byte;
    assign is_al  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_dg  = (c >= "0" && c <= "9");
    assign is_id  = is_al || is_dg || c == "_";
    assign is_str = c != CH_DQUOTE && c >= CH_SPACE && c <= CH_TILDE;

    // Decimal step on the held value: acc * 10 + digit, by shifts and adds.
    assign dig_sum = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {32'd0, c[3:0]};

    assign accept     = s_valid && s_ready;
    assign s_ready    = push_ready;
    assign cfg_ready  = 1'b1;
    assign push_valid = accept && cnt != 3'd0;

    always_comb begin
        push_data.recs  = recs;
        push_data.count = cnt;
        push_data.line  = line_reg;
        push_data.col   = col_reg;
    end

    // Scan step: flush at end of input, else extend or finish the pending token.
    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        tc_next    = tc_reg;
        cand_next  = cand_reg;
        held_next  = held_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        recs       = '0;
        cnt        = 3'd0;
        redo       = 1'b1;
        tc_wide    = '0;

        if (s_end_of_input) begin
            unique case (state_reg)
                ST_IDENT, ST_IDENT_OVF: begin
                    recs[cnt[1:0]] = mk_rec(REC_TOKEN, kw_kind(cand_reg, tc_reg), '0, '0,
                                            tc_reg, ERR_NONE);
                    cnt = cnt + 3'd1;
                end
                ST_ZERO: begin
                    recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_INT, '0, '0, '0, ERR_NONE);
                    cnt = cnt + 3'd1;
                end
                ST_INT, ST_INT_OVF: begin
                    recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_INT, acc_reg, '0, '0, ERR_NONE);
                    cnt = cnt + 3'd1;
                end
                ST_CHAR_OPEN: begin
                    recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0, ERR_BAD_CHAR);
                    cnt = cnt + 3'd1;
                end
                ST_CHAR_GOT: begin
                    recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0, ERR_NO_QUOTE);
                    cnt = cnt + 3'd1;
                    recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_CHAR, '0, held_reg, '0, ERR_NONE);
                    cnt = cnt + 3'd1;
                end
                ST_STR, ST_STR_OVF: begin
                    recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0, ERR_NO_DQUOTE);
                    cnt = cnt + 3'd1;
                end
                ST_LT: begin
                    recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_LT, '0, '0, '0, ERR_NONE);
                    cnt = cnt + 3'd1;
                end
                ST_GT: begin
                    recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_GT, '0, '0, '0, ERR_NONE);
                    cnt = cnt + 3'd1;
                end
                ST_EQ: begin
                    recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_ASSIGN, '0, '0, '0, ERR_NONE);
                    cnt = cnt + 3'd1;
                end
                ST_BANG: begin
                    recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0, ERR_LONE_BANG);
                    cnt = cnt + 3'd1;
                end
                default: begin
                end
            endcase
            recs[cnt[1:0]] = mk_rec(REC_END, TOK_IDENT, '0, '0, '0, ERR_NONE);
            cnt        = cnt + 3'd1;
            state_next = ST_IDLE;
            acc_next   = '0;
            tc_next    = '0;
            cand_next  = KwAll;
            held_next  = '0;
            line_next  = 20'd1;
            col_next   = 16'd1;
        end else begin
            // Pending token: extend or emit it; an unused byte goes back to idle.
            if (state_reg != ST_IDLE) begin
                state_next = ST_IDLE;
                unique case (state_reg)
                    ST_IDENT: begin
                        if (is_id) begin
                            redo = 1'b0;
                            if (tc_reg >= text_limit_reg) begin
                                state_next = ST_IDENT_OVF;
                                recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                        ERR_TOO_LONG);
                                cnt = cnt + 3'd1;
                            end else begin
                                state_next = ST_IDENT;
                                cand_next  = kw_filter(cand_reg, tc_reg, c);
                                tc_next    = tc_reg + 8'd1;
                                recs[cnt[1:0]] = mk_rec(REC_TEXT, TOK_IDENT, '0, c, '0,
                                                        ERR_NONE);
                                cnt = cnt + 3'd1;
                            end
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_TOKEN, kw_kind(cand_reg, tc_reg), '0,
                                                    '0, tc_reg, ERR_NONE);
                            cnt = cnt + 3'd1;
                        end
                    end
                    ST_IDENT_OVF: begin
                        if (is_id) begin
                            redo       = 1'b0;
                            state_next = ST_IDENT_OVF;
                            recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                    ERR_TOO_LONG);
                            cnt = cnt + 3'd1;
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_TOKEN, kw_kind(cand_reg, tc_reg), '0,
                                                    '0, tc_reg, ERR_NONE);
                            cnt = cnt + 3'd1;
                        end
                    end
                    ST_ZERO: begin
                        if (is_dg) begin
                            redo       = 1'b0;
                            state_next = ST_ZERO;
                            recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                    ERR_LEAD_ZERO);
                            cnt = cnt + 3'd1;
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_INT, '0, '0, '0, ERR_NONE);
                            cnt = cnt + 3'd1;
                        end
                    end
                    ST_INT: begin
                        if (is_dg) begin
                            redo = 1'b0;
                            if (dig_sum > {4'd0, int_limit_reg}) begin
                                state_next = ST_INT_OVF;
                                recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                        ERR_TOO_LARGE);
                                cnt = cnt + 3'd1;
                            end else begin
                                state_next = ST_INT;
                                acc_next   = dig_sum[31:0];
                            end
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_INT, acc_reg, '0, '0,
                                                    ERR_NONE);
                            cnt = cnt + 3'd1;
                        end
                    end
                    ST_INT_OVF: begin
                        if (is_dg) begin
                            redo       = 1'b0;
                            state_next = ST_INT_OVF;
                            recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                    ERR_TOO_LARGE);
                            cnt = cnt + 3'd1;
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_INT, acc_reg, '0, '0,
                                                    ERR_NONE);
                            cnt = cnt + 3'd1;
                        end
                    end
                    ST_CHAR_OPEN: begin
                        if (is_id || c == "+" || c == "-" || c == "*" || c == "/") begin
                            redo       = 1'b0;
                            held_next  = c;
                            state_next = ST_CHAR_GOT;
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                    ERR_BAD_CHAR);
                            cnt = cnt + 3'd1;
                        end
                    end
                    ST_CHAR_GOT: begin
                        if (c == "'") begin
                            redo = 1'b0;
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                    ERR_NO_QUOTE);
                            cnt = cnt + 3'd1;
                        end
                        recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_CHAR, '0, held_reg, '0,
                                                ERR_NONE);
                        cnt = cnt + 3'd1;
                    end
                    ST_STR: begin
                        if (is_str) begin
                            redo = 1'b0;
                            if (tc_reg >= text_limit_reg) begin
                                state_next = ST_STR_OVF;
                                recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                        ERR_TOO_LONG);
                                cnt = cnt + 3'd1;
                            end else begin
                                state_next = ST_STR;
                                recs[cnt[1:0]] = mk_rec(REC_TEXT, TOK_STRING, '0, c, '0,
                                                        ERR_NONE);
                                cnt     = cnt + 3'd1;
                                tc_wide = {1'b0, tc_reg} + 9'd1;
                                // A backslash goes out twice and counts twice.
                                if (c == "\\") begin
                                    recs[cnt[1:0]] = mk_rec(REC_TEXT, TOK_STRING, '0, c, '0,
                                                            ERR_NONE);
                                    cnt     = cnt + 3'd1;
                                    tc_wide = tc_wide + 9'd1;
                                end
                                tc_next = tc_wide[8] ? 8'd255 : tc_wide[7:0];
                            end
                        end else if (c == CH_DQUOTE) begin
                            redo = 1'b0;
                            recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_STRING, '0, '0, tc_reg,
                                                    ERR_NONE);
                            cnt = cnt + 3'd1;
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                    ERR_NO_DQUOTE);
                            cnt = cnt + 3'd1;
                        end
                    end
                    ST_STR_OVF: begin
                        if (is_str) begin
                            redo       = 1'b0;
                            state_next = ST_STR_OVF;
                            recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                    ERR_TOO_LONG);
                            cnt = cnt + 3'd1;
                        end else if (c == CH_DQUOTE) begin
                            redo = 1'b0;
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                    ERR_NO_DQUOTE);
                            cnt = cnt + 3'd1;
                        end
                    end
                    ST_LT: begin
                        redo = (c != "=");
                        recs[cnt[1:0]] = mk_rec(REC_TOKEN, redo ? TOK_LT : TOK_LE, '0, '0,
                                                '0, ERR_NONE);
                        cnt = cnt + 3'd1;
                    end
                    ST_GT: begin
                        redo = (c != "=");
                        recs[cnt[1:0]] = mk_rec(REC_TOKEN, redo ? TOK_GT : TOK_GE, '0, '0,
                                                '0, ERR_NONE);
                        cnt = cnt + 3'd1;
                    end
                    ST_EQ: begin
                        redo = (c != "=");
                        recs[cnt[1:0]] = mk_rec(REC_TOKEN, redo ? TOK_ASSIGN : TOK_EQEQ,
                                                '0, '0, '0, ERR_NONE);
                        cnt = cnt + 3'd1;
                    end
                    ST_BANG: begin
                        redo = (c != "=");
                        if (redo) begin
                            recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                    ERR_LONE_BANG);
                        end else begin
                            recs[cnt[1:0]] = mk_rec(REC_TOKEN, TOK_NE, '0, '0, '0,
                                                    ERR_NONE);
                        end
                        cnt = cnt + 3'd1;
                    end
                    default: begin
                    end
                endcase
            end

            // Idle byte: skip, start a token, or emit a one-char token or error.
            if (redo) begin
                if (c == CH_SPACE || c == "\t" || c == 8'd0 || c == CH_CR || c == CH_LF) begin
                    state_next = ST_IDLE;
                end else if (is_al || c == "_") begin
                    cand_next = KwAll;
                    if (text_limit_reg == 8'd0) begin
                        tc_next    = '0;
                        state_next = ST_IDENT_OVF;
                        recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                ERR_TOO_LONG);
                    end else begin
                        tc_next    = 8'd1;
                        cand_next  = kw_filter(KwAll, 8'd0, c);
                        state_next = ST_IDENT;
                        recs[cnt[1:0]] = mk_rec(REC_TEXT, TOK_IDENT, '0, c, '0, ERR_NONE);
                    end
                    cnt = cnt + 3'd1;
                end else if (is_dg) begin
                    if (c == "0") begin
                        acc_next   = '0;
                        state_next = ST_ZERO;
                    end else if ({28'd0, c[3:0]} > int_limit_reg) begin
                        acc_next   = '0;
                        state_next = ST_INT_OVF;
                        recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0,
                                                ERR_TOO_LARGE);
                        cnt = cnt + 3'd1;
                    end else begin
                        acc_next   = {28'd0, c[3:0]};
                        state_next = ST_INT;
                    end
                end else if (c == "'") begin
                    state_next = ST_CHAR_OPEN;
                end else if (c == CH_DQUOTE) begin
                    tc_next    = '0;
                    state_next = ST_STR;
                end else if (c == "<") begin
                    state_next = ST_LT;
                end else if (c == ">") begin
                    state_next = ST_GT;
                end else if (c == "=") begin
                    state_next = ST_EQ;
                end else if (c == "!") begin
                    state_next = ST_BANG;
                end else if (simple_tok(c) != TOK_IDENT) begin
                    state_next = ST_IDLE;
                    recs[cnt[1:0]] = mk_rec(REC_TOKEN, simple_tok(c), '0, '0, '0, ERR_NONE);
                    cnt = cnt + 3'd1;
                end else begin
                    state_next = ST_IDLE;
                    recs[cnt[1:0]] = mk_rec(REC_ERROR, TOK_IDENT, '0, '0, '0, ERR_ILLEGAL);
                    cnt = cnt + 3'd1;
                end
            end

            // Position counters saturate at their maximum.
            if (c == CH_LF) begin
                if (line_reg != LineMax) begin
                    line_next = line_reg + 20'd1;
                end
                col_next = 16'd1;
            end else if (col_reg != ColMax) begin
                col_next = col_reg + 16'd1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_limit_reg  <= IntLimitReset;
            text_limit_reg <= TextLimitReset;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_INT_LIMIT) begin
                int_limit_reg <= cfg_data;
            end else begin
                text_limit_reg <= cfg_data[7:0];
            end
        end
    end

    // Scanner state, advanced once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            tc_reg    <= '0;
            cand_reg  <= KwAll;
            held_reg  <= '0;
            line_reg  <= 20'd1;
            col_reg   <= 16'd1;
        end else if (accept) begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            tc_reg    <= tc_next;
            cand_reg  <= cand_next;
            held_reg  <= held_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

endmodule

@@ rtl/core/lex_queue.sv @@
module lex_queue #(
    parameter int DEPTH = lex_pkg::QueueDepth
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  lex_pkg::bundle_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output lex_pkg::bundle_t  pop_data
);
    import lex_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    bundle_t         mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign push_ready = count_reg != CntW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Bundle storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers, wrapping at DEPTH, and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CntW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

endmodule

@@ rtl/core/lex_back.sv @@
module lex_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  lex_pkg::bundle_t  pop_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_record_kind,
    output logic [5:0]        m_token_kind,
    output logic [31:0]       m_int_value,
    output logic [7:0]        m_char_value,
    output logic [7:0]        m_text_length,
    output logic [19:0]       m_line_number,
    output logic [15:0]       m_column_number,
    output logic [3:0]        m_error_code,
    output logic              m_last_record
);
    import lex_pkg::*;

    logic [1:0] idx_reg;
    rec_t       cur;
    logic       last;

    assign cur  = pop_data.recs[idx_reg];
    assign last = {1'b0, idx_reg} == pop_data.count - 3'd1;

    assign m_valid         = pop_valid;
    assign m_record_kind   = cur.kind;
    assign m_token_kind    = cur.tok;
    assign m_int_value     = cur.ival;
    assign m_char_value    = cur.cval;
    assign m_text_length   = cur.tlen;
    assign m_line_number   = pop_data.line;
    assign m_column_number = pop_data.col;
    assign m_error_code    = cur.err;
    assign m_last_record   = last;

    // Release the bundle once its final record has been taken.
    assign pop_ready = m_ready && last;

    // Record index within the head bundle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

@@ rtl/core/c_subset_lexical_scanner.sv @@
// Lexical scanner for a small C subset.
// Source bytes enter on the s_ channel (s_source_byte, s_end_of_input) with
// valid/ready; each transaction yields up to three records on the m_ channel:
// tokens, error reports, the end mark, and identifier or string characters.
// m_last_record flags the final record produced by one input byte.
// The cfg_ channel writes int_limit (index 0) and text_limit (index 1); it is
// always ready and should be used only while the scanner is idle.
// A byte is scanned in the cycle it is accepted, so one byte per cycle is
// taken while the bundle queue has room. Each bundle is registered in the
// queue; its first record appears on m_ once it reaches the head, and the
// back end sends one record per cycle while m_ready is high. Throughput is
// then one byte per cycle when every byte gives at most one record.
// When m_ready is low the queue of QUEUE_DEPTH bundles absorbs bytes; once it
// is full s_ready drops until records are drained.
// Synchronous active-low reset returns the scanner to idle at line 1, column
// 1, empties the queue and restores the default limits.
module c_subset_lexical_scanner #(
    parameter int QUEUE_DEPTH = lex_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_byte,
    input  logic        s_end_of_input,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_record_kind,
    output logic [5:0]  m_token_kind,
    output logic [31:0] m_int_value,
    output logic [7:0]  m_char_value,
    output logic [7:0]  m_text_length,
    output logic [19:0] m_line_number,
    output logic [15:0] m_column_number,
    output logic [3:0]  m_error_code,
    output logic        m_last_record
);
    import lex_pkg::*;

    bundle_t push_data, pop_data;
    logic    push_valid, push_ready, pop_valid, pop_ready;

    lex_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_source_byte  (s_source_byte),
        .s_end_of_input (s_end_of_input),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    lex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lex_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_record_kind   (m_record_kind),
        .m_token_kind    (m_token_kind),
        .m_int_value     (m_int_value),
        .m_char_value    (m_char_value),
        .m_text_length   (m_text_length),
        .m_line_number   (m_line_number),
        .m_column_number (m_column_number),
        .m_error_code    (m_error_code),
        .m_last_record   (m_last_record)
    );

endmodule
